FILE: sv/occupancy_grid_frontier_detector_unit_assert.svh
`ifndef OCCUPANCY_GRID_FRONTIER_DETECTOR_UNIT_ASSERT_SVH
`define OCCUPANCY_GRID_FRONTIER_DETECTOR_UNIT_ASSERT_SVH

// clocked check, quiet while reset is low
`define OGFD_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define OGFD_IMPLIES(lbl, ante, cons, msg) \
	`OGFD_CHECK(lbl, (ante) |-> (cons), msg)

`endif

FILE: sv/ogfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ogfd_pkg;

	// raster coordinates are 8 bits, grid up to 256 x 256
	localparam int COL_W      = 8;
	localparam int ROW_W      = 8;
	localparam int MAX_WIDTH  = 1 << COL_W;
	localparam int MAX_HEIGHT = 1 << ROW_W;
	localparam int DIM_W      = COL_W + 1;
	localparam int MIN_DIM    = 6;

	// 2-bit cell codes
	typedef logic [1:0] code_t;
	localparam code_t CODE_OTHER    = 2'd0;
	localparam code_t CODE_FREE     = 2'd1;
	localparam code_t CODE_UNKNOWN  = 2'd2;
	localparam code_t CODE_OCCUPIED = 2'd3;

	// raw occupancy values
	localparam logic [7:0] VAL_UNKNOWN  = 8'hFF;
	localparam logic [7:0] VAL_FREE     = 8'd0;
	localparam logic [7:0] VAL_OCCUPIED = 8'd100;

	// register indexes
	localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
	localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
	localparam logic [2:0] REG_ROBOT_COL   = 3'd2;
	localparam logic [2:0] REG_ROBOT_ROW   = 3'd3;
	localparam logic [2:0] REG_POSE_VALID  = 3'd4;
	localparam logic [2:0] REG_EXCL_DIST   = 3'd5;

	localparam int PADDR_W = 5;
	localparam int DIST_W  = 17;

	// line store word: one code per row slot, four slots
	localparam int SLOTS  = 4;
	localparam int WORD_W = SLOTS * 2;

	function automatic code_t classify(input logic [7:0] v);
		code_t c;
		begin
			if (v == VAL_UNKNOWN) c = CODE_UNKNOWN;
			else if (v == VAL_FREE) c = CODE_FREE;
			else if (v == VAL_OCCUPIED) c = CODE_OCCUPIED;
			else c = CODE_OTHER;
			return c;
		end
	endfunction

	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		begin
			if (v < DIM_W'(MIN_DIM)) r = DIM_W'(MIN_DIM);
			else if (v > hi) r = hi;
			else r = v;
			return r;
		end
	endfunction

endpackage

`default_nettype wire

FILE: sv/ogfd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ogfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/occupancy_grid_frontier_detector_unit.sv
// a cell accepted into the stage 1 registers reaches m_axis through the stage 2 and output registers
// throughput: one cell per clock, stalled only by m_axis_tready
// the line store is one 256 x 8 ram (four row slots per column), read-modify-write per cell
// reset (arst_n low, asynchronous): raster position, window, pipeline valids and registers
// return to their defaults; the line store is not cleared and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module occupancy_grid_frontier_detector_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// apb configuration
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ogfd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	// input cells
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [7:0]                   s_axis_tdata,  // [7:0] cell_value (signed)
	input  wire logic                         s_axis_tuser,  // [0] frame_start
	// results
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic      [15:0]                  m_axis_tdata,  // [7:0] center_col, [15:8] center_row
	output logic                              m_axis_tuser,  // [0] is_frontier
	output logic                              m_axis_tlast   // frame_last
);

	import ogfd_pkg::*;

	// configuration registers
	logic [DIM_W-1:0]  grid_width_q;
	logic [DIM_W-1:0]  grid_height_q;
	logic [COL_W-1:0]  robot_col_q;
	logic [ROW_W-1:0]  robot_row_q;
	logic              pose_valid_q;
	logic [DIST_W-1:0] excl_dist_q;
	logic [DIM_W-1:0]  w_sat;
	logic [DIM_W-1:0]  h_sat;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign w_sat  = sat_dim(grid_width_q, DIM_W'(MAX_WIDTH));
	assign h_sat  = sat_dim(grid_height_q, DIM_W'(MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= DIM_W'(200);
			grid_height_q <= DIM_W'(200);
			robot_col_q   <= '0;
			robot_row_q   <= '0;
			pose_valid_q  <= 1'b0;
			excl_dist_q   <= DIST_W'(100);
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[DIM_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[DIM_W-1:0];
				REG_ROBOT_COL:   robot_col_q   <= pwdata[COL_W-1:0];
				REG_ROBOT_ROW:   robot_row_q   <= pwdata[ROW_W-1:0];
				REG_POSE_VALID:  pose_valid_q  <= pwdata[0];
				REG_EXCL_DIST:   excl_dist_q   <= pwdata[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_GRID_WIDTH:  prdata = 32'(grid_width_q);
			REG_GRID_HEIGHT: prdata = 32'(grid_height_q);
			REG_ROBOT_COL:   prdata = 32'(robot_col_q);
			REG_ROBOT_ROW:   prdata = 32'(robot_row_q);
			REG_POSE_VALID:  prdata = 32'(pose_valid_q);
			REG_EXCL_DIST:   prdata = 32'(excl_dist_q);
			default:         prdata = '0;
		endcase
	end

	// whole pipeline moves together whenever the output register can take a word
	logic advance;
	logic accept;

	assign advance       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = advance;
	assign accept        = s_axis_tvalid && advance;

	// stage 0: raster position of the arriving cell
	logic [COL_W-1:0] raster_col_q;
	logic [ROW_W-1:0] raster_row_q;
	logic [DIM_W-1:0] c_start, r_start, r_inc, c_next, r_next;
	logic [COL_W-1:0] col_0, col_d;
	logic [ROW_W-1:0] row_0, row_d;

	always_comb begin
		c_start = s_axis_tuser ? '0 : DIM_W'(raster_col_q);
		r_start = s_axis_tuser ? '0 : DIM_W'(raster_row_q);
		// position beyond the grid wraps
		if (c_start >= w_sat) begin
			col_0 = '0;
			r_inc = r_start + DIM_W'(1);
		end else begin
			col_0 = c_start[COL_W-1:0];
			r_inc = r_start;
		end
		row_0 = (r_inc >= h_sat) ? '0 : r_inc[ROW_W-1:0];

		c_next = DIM_W'(col_0) + DIM_W'(1);
		r_next = DIM_W'(row_0) + DIM_W'(1);
		if (c_next >= w_sat) begin
			col_d = '0;
			row_d = (r_next >= h_sat) ? '0 : r_next[ROW_W-1:0];
		end else begin
			col_d = c_next[COL_W-1:0];
			row_d = row_0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raster_col_q <= '0;
			raster_row_q <= '0;
		end else if (accept) begin
			raster_col_q <= col_d;
			raster_row_q <= row_d;
		end
	end

	// line store ram
	logic              ram_we;
	logic [WORD_W-1:0] ram_rdata;
	logic [WORD_W-1:0] word_new;

	// stage 1 registers
	logic              valid_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	code_t             code_s1;
	logic              fwd_s1;
	logic [WORD_W-1:0] fwd_word_s1;

	assign ram_we = valid_s1 && advance;

	ogfd_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(col_s1),
		.wdata(word_new),
		.re   (accept),
		.raddr(col_0),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
			// same column read while being written: take the written word
			fwd_s1   <= accept && ram_we && (col_0 == col_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			col_s1      <= col_0;
			row_s1      <= row_0;
			code_s1     <= classify(s_axis_tdata);
			fwd_word_s1 <= word_new;
		end
	end

	// stage 1: assemble the new window column and write back the line store
	logic [WORD_W-1:0] word_rd;
	logic [9:0]        col_bits;
	logic [1:0]        slot;
	logic [49:0]       window_q;
	logic [COL_W-1:0]  cc_1, acx_1;
	logic [ROW_W-1:0]  cr_1, acy_1;
	logic              produce_1, edge_ok_1, last_1;

	assign word_rd = fwd_s1 ? fwd_word_s1 : ram_rdata;

	always_comb begin
		// oldest row first: slot (r + k) mod 4 holds row r-4+k
		for (int k = 0; k < SLOTS; k++) begin
			slot = row_s1[1:0] + 2'(k);
			col_bits[2*k +: 2] = word_rd[2*slot +: 2];
		end
		col_bits[9:8] = code_s1;
		word_new = word_rd;
		word_new[2*row_s1[1:0] +: 2] = code_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (advance && valid_s1) begin
			window_q <= {col_bits, window_q[49:10]};
		end
	end

	always_comb begin
		cc_1      = col_s1 - COL_W'(2);
		cr_1      = row_s1 - ROW_W'(2);
		produce_1 = (col_s1 >= COL_W'(4)) && (row_s1 >= ROW_W'(4));
		edge_ok_1 = (cc_1 >= COL_W'(3)) && ((DIM_W'(cc_1) + DIM_W'(4)) <= w_sat)
			&& (cr_1 >= ROW_W'(3)) && ((DIM_W'(cr_1) + DIM_W'(4)) <= h_sat);
		last_1    = (DIM_W'(col_s1) == w_sat - DIM_W'(1))
			&& (DIM_W'(row_s1) == h_sat - DIM_W'(1));
		acx_1     = (cc_1 >= robot_col_q) ? cc_1 - robot_col_q : robot_col_q - cc_1;
		acy_1     = (cr_1 >= robot_row_q) ? cr_1 - robot_row_q : robot_row_q - cr_1;
	end

	// stage 2 registers
	logic                 valid_s2;
	logic [COL_W-1:0]     cc_s2;
	logic [ROW_W-1:0]     cr_s2;
	logic                 edge_ok_s2, last_s2;
	logic [2*COL_W-1:0]   sqx_s2;
	logic [2*ROW_W-1:0]   sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && produce_1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cc_s2      <= cc_1;
			cr_s2      <= cr_1;
			edge_ok_s2 <= edge_ok_1;
			last_s2    <= last_1;
			sqx_s2     <= acx_1 * acx_1;
			sqy_s2     <= acy_1 * acy_1;
		end
	end

	// stage 2: judge the window centre; window_q holds this cell's window here
	logic              occ_near, unk_near, centre_free, far_ok, frontier_2;
	logic [DIST_W-1:0] dist_2;
	code_t             wv;

	always_comb begin
		occ_near = 1'b0;
		unk_near = 1'b0;
		for (int dr = 0; dr < 5; dr++) begin
			for (int dc = 0; dc < 5; dc++) begin
				wv = window_q[dc*10 + dr*2 +: 2];
				if (wv == CODE_OCCUPIED) occ_near = 1'b1;
				if (wv == CODE_UNKNOWN && dr >= 1 && dr <= 3 && dc >= 1 && dc <= 3)
					unk_near = 1'b1;
			end
		end
		centre_free = (window_q[2*10 + 2*2 +: 2] == CODE_FREE);
		dist_2      = DIST_W'(sqx_s2) + DIST_W'(sqy_s2);
		far_ok      = !pose_valid_q || (dist_2 > excl_dist_q);
		frontier_2  = centre_free && unk_near && !occ_near && edge_ok_s2 && far_ok;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_axis_tdata <= {cr_s2, cc_s2};
			m_axis_tuser <= frontier_2;
			m_axis_tlast <= last_s2;
		end
	end

	`include "occupancy_grid_frontier_detector_unit_assert.svh"

	// frontier cells sit at least three cells in from the top and left edges
	`OGFD_IMPLIES(a_frontier_inside, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[7:0] >= 8'd3) && (m_axis_tdata[15:8] >= 8'd3), "frontier too close to grid edge")
	// the last result lies two cells from the right edge, so it is never a frontier
	`OGFD_IMPLIES(a_last_not_frontier, m_axis_tvalid && m_axis_tlast, !m_axis_tuser, "last result flagged as frontier")
	// forwarding only ever follows an accepted cell
	`OGFD_IMPLIES(a_fwd_has_item, fwd_s1, valid_s1, "forward flag without item in stage 1")

endmodule

`default_nettype wire

FILE: test/tb_occupancy_grid_frontier_detector_unit.sv
`timescale 1ns / 1ps

module tb_occupancy_grid_frontier_detector_unit;
	import ogfd_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [7:0] col;
		logic [7:0] row;
		logic       frontier;
		logic       last;
	} judgment_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = '0;   // [7:0] cell_value (signed)
	logic                s_axis_tuser = 1'b0; // [0] frame_start

	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [15:0]         m_axis_tdata;        // [7:0] center_col, [15:8] center_row
	logic                m_axis_tuser;        // [0] is_frontier
	logic                m_axis_tlast;        // frame_last

	// register shadows
	logic [DIM_W-1:0]    cfg_width = 9'd200;
	logic [DIM_W-1:0]    cfg_height = 9'd200;
	logic [7:0]          cfg_robot_col = '0;
	logic [7:0]          cfg_robot_row = '0;
	logic                cfg_pose_valid = 1'b0;
	logic [DIST_W-1:0]   cfg_excl_dist = 17'd100;

	// predictor state
	code_t               row_mem [SLOTS][MAX_WIDTH];
	code_t               wnd [5][5];
	int                  rast_col = 0;
	int                  rast_row = 0;

	judgment_t           pending_judgments [$];
	int                  mismatch_count = 0;
	int                  quiet_cycles = 0;
	int                  cells_sent = 0;
	int                  sender_idle_pct = 0;
	int                  sink_stall_pct = 0;

	occupancy_grid_frontier_detector_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	function automatic int eff_dim(input logic [DIM_W-1:0] v, input int hi);
		if (v < MIN_DIM) return MIN_DIM;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	function automatic code_t cell_code(input logic [7:0] v);
		case (v)
			VAL_UNKNOWN:  return CODE_UNKNOWN;
			VAL_FREE:     return CODE_FREE;
			VAL_OCCUPIED: return CODE_OCCUPIED;
			default:      return CODE_OTHER;
		endcase
	endfunction

	// advances the raster and queues the judgment of the window center, if any
	task automatic judge_cell(input logic [7:0] value, input logic frame_start);
		int w, h, cc, cr, dx, dy, dr, dc, k;
		code_t code;
		logic unknown_near, occupied_near, ok;
		judgment_t j;
		w = eff_dim(cfg_width, MAX_WIDTH);
		h = eff_dim(cfg_height, MAX_HEIGHT);
		code = cell_code(value);
		if (frame_start) begin
			rast_col = 0;
			rast_row = 0;
		end
		if (rast_col >= w) begin
			rast_col = 0;
			rast_row++;
		end
		if (rast_row >= h)
			rast_row = 0;
		for (dc = 0; dc < 4; dc++)
			for (dr = 0; dr < 5; dr++)
				wnd[dr][dc] = wnd[dr][dc + 1];
		// rows r-4 .. r-1 come out of the slots in rotation
		for (k = 0; k < 4; k++)
			wnd[k][4] = row_mem[(rast_row + k) % SLOTS][rast_col];
		wnd[4][4] = code;
		row_mem[rast_row % SLOTS][rast_col] = code;

		if (rast_col >= 4 && rast_row >= 4) begin
			unknown_near = 1'b0;
			occupied_near = 1'b0;
			for (dr = 0; dr < 5; dr++)
				for (dc = 0; dc < 5; dc++) begin
					if (wnd[dr][dc] == CODE_OCCUPIED)
						occupied_near = 1'b1;
					if (wnd[dr][dc] == CODE_UNKNOWN && dr >= 1 && dr <= 3 && dc >= 1 && dc <= 3)
						unknown_near = 1'b1;
				end
			cc = rast_col - 2;
			cr = rast_row - 2;
			ok = wnd[2][2] == CODE_FREE && unknown_near && !occupied_near &&
				cc >= 3 && cc + 4 <= w && cr >= 3 && cr + 4 <= h;
			if (ok && cfg_pose_valid) begin
				dx = cc - int'(cfg_robot_col);
				dy = cr - int'(cfg_robot_row);
				ok = (dx * dx + dy * dy) > int'(cfg_excl_dist);
			end
			j.col = 8'(cc);
			j.row = 8'(cr);
			j.frontier = ok;
			j.last = (rast_col == w - 1 && rast_row == h - 1);
			pending_judgments.insert(pending_judgments.size(), j);
		end

		rast_col++;
		if (rast_col >= w) begin
			rast_col = 0;
			rast_row++;
			if (rast_row >= h)
				rast_row = 0;
		end
	endtask

	function automatic void compare_field(input string what, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endfunction

	// result check first, then prediction, so a new cell never pairs with an older word
	always @(posedge clk) begin
		judgment_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_judgments.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result, expected none, actual col %0d row %0d",
						$time, m_axis_tdata[7:0], m_axis_tdata[15:8]);
				end else begin
					want = pending_judgments.pop_front();
					compare_field("center_col", want.col, m_axis_tdata[7:0]);
					compare_field("center_row", want.row, m_axis_tdata[15:8]);
					compare_field("is_frontier", 8'(want.frontier), 8'(m_axis_tuser));
					compare_field("frame_last", 8'(want.last), 8'(m_axis_tlast));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				judge_cell(s_axis_tdata, s_axis_tuser);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_cell(input logic [7:0] value, input logic frame_start);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tuser <= frame_start;
		do @(posedge clk); while (!s_axis_tready);
		cells_sent++;
	endtask

	// stop sending and let every expected word come out, plus the pipeline tail
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_judgments.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_GRID_WIDTH:  cfg_width = value[DIM_W-1:0];
			REG_GRID_HEIGHT: cfg_height = value[DIM_W-1:0];
			REG_ROBOT_COL:   cfg_robot_col = value[7:0];
			REG_ROBOT_ROW:   cfg_robot_row = value[7:0];
			REG_POSE_VALID:  cfg_pose_valid = value[0];
			REG_EXCL_DIST:   cfg_excl_dist = value[DIST_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input int w, input int h, input int rcol, input int rrow,
		input int pose, input int excl);
		settle();
		write_reg(REG_GRID_WIDTH, w);
		write_reg(REG_GRID_HEIGHT, h);
		write_reg(REG_ROBOT_COL, rcol);
		write_reg(REG_ROBOT_ROW, rrow);
		write_reg(REG_POSE_VALID, pose);
		write_reg(REG_EXCL_DIST, excl);
	endtask

	function automatic logic [7:0] random_cell(input int occ_pct);
		int p;
		p = $urandom_range(99);
		if (p < occ_pct) return VAL_OCCUPIED;
		if (p < occ_pct + 20) return VAL_UNKNOWN;
		if (p < 92) return VAL_FREE;
		return 8'($urandom);
	endfunction

	// a rare frame_start lands mid-frame
	task automatic send_cells(input int count, input bit with_start, input int occ_pct);
		int i;
		for (i = 0; i < count; i++)
			send_cell(random_cell(occ_pct), (with_start && i == 0) || $urandom_range(299) == 0);
	endtask

	// 7x7 grid, one unknown next to the center, an occupied cell and unclassified values in the corners
	task automatic send_pattern_frame();
		int r, c;
		logic [7:0] v;
		for (r = 0; r < 7; r++)
			for (c = 0; c < 7; c++) begin
				if (r == 2 && c == 2) v = VAL_UNKNOWN;
				else if (r == 0 && c == 0) v = VAL_OCCUPIED;
				else if (r == 0 && c == 6) v = 8'h7F;
				else if (r == 6 && c == 0) v = 8'h80;
				else if (r == 6 && c == 6) v = 8'h01;
				else v = VAL_FREE;
				send_cell(v, r == 0 && c == 0);
			end
	endtask

	task automatic test_frontier_directed();
		configure(7, 7, 0, 0, 0, 100);
		send_pattern_frame();
	endtask

	task automatic test_robot_exclusion();
		// robot on the cell itself, then just outside the radius and exactly on it, then far off
		configure(7, 7, 3, 3, 1, 0);
		send_pattern_frame();
		configure(7, 7, 0, 3, 1, 8);
		send_pattern_frame();
		configure(7, 7, 0, 3, 1, 9);
		send_pattern_frame();
		configure(7, 7, 255, 255, 1, 131071);
		send_pattern_frame();
	endtask

	task automatic test_size_extremes();
		int i;
		// widest grid: one full row and the first cell of the next
		configure(511, 0, 255, 0, 1, 0);
		for (i = 0; i < MAX_WIDTH + 1; i++)
			send_cell(random_cell(3), i == 0);
		// narrow to 14 mid-frame; rows 1..5 leave every slot of columns 0..13 written
		settle();
		write_reg(REG_GRID_WIDTH, 14);
		for (i = 0; i < 13 + 14 * 4; i++)
			send_cell(random_cell(3), 1'b0);
		configure(5, 5, 2, 2, 1, 1);
		send_cells(MIN_DIM * MIN_DIM, 1'b1, 3);
	endtask

	task automatic test_implicit_frames();
		configure(8, 6, 1, 1, 0, 4);
		send_cells(8 * 6 + 19, 1'b1, 3);
		// shrink and grow without frame_start so the raster wraps on its own
		settle();
		write_reg(REG_GRID_WIDTH, 12);
		send_cells(30, 1'b0, 3);
		settle();
		write_reg(REG_GRID_HEIGHT, 0);
		send_cells(48, 1'b0, 3);
		settle();
		write_reg(REG_GRID_WIDTH, 7);
		send_cells(30, 1'b0, 3);
	endtask

	task automatic test_random_stream();
		int phase, phase_base, w, h, ew, eh, occ, excl;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin sender_idle_pct = 76; sink_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  sink_stall_pct = 76; end
				default: begin sender_idle_pct = 24; sink_stall_pct = 24; end
			endcase
			phase_base = cells_sent;
			while (cells_sent - phase_base < 40) begin
				w = ($urandom_range(9) == 0) ? $urandom_range(5) : $urandom_range(6, 10);
				h = ($urandom_range(9) == 0) ? $urandom_range(5) : $urandom_range(6, 8);
				excl = ($urandom_range(9) == 0) ? 131071 : $urandom_range(40);
				configure(w, h, $urandom_range(15), $urandom_range(15), $urandom_range(1), excl);
				ew = eff_dim(cfg_width, MAX_WIDTH);
				eh = eff_dim(cfg_height, MAX_HEIGHT);
				occ = $urandom_range(10);
				if ($urandom_range(9) == 0)
					send_cells($urandom_range(1, ew * eh - 1), 1'b1, occ);
				else
					send_cells(ew * eh, $urandom_range(9) != 0, occ);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_frontier_directed();
		test_robot_exclusion();
		test_size_extremes();
		test_implicit_frames();
		test_random_stream();
		settle();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
